[sv/hslrgb_pkg.sv]
`timescale 1ns / 1ps

package hslrgb_pkg;

	localparam int DEF_LEVEL_FRACTION_BITS = 15;
	localparam int COLOR_W = 16;
	localparam int HUE_W = 16;
	localparam int REM_W = 13;

	// One 60 degree sector in 1/128 degree units, split as an odd factor and a shift.
	localparam int SECTOR_UNITS = 7680;
	localparam int HUE_LIMIT = 6 * SECTOR_UNITS;
	localparam int DIV_SHIFT = 9;
	localparam int DIV_ODD = 15;

	localparam logic [COLOR_W-1:0] FULL_SCALE_RESET = 16'd255;

	typedef enum logic [2:0] {
		SEC_R_Y,
		SEC_Y_G,
		SEC_G_C,
		SEC_C_B,
		SEC_B_M,
		SEC_M_R
	} sector_t;

endpackage

[sv/hslrgb_ramp_div.sv]
`timescale 1ns / 1ps

module hslrgb_ramp_div import hslrgb_pkg::*; #(
	parameter int LEVEL_FRACTION_BITS = DEF_LEVEL_FRACTION_BITS,
	localparam int LW = LEVEL_FRACTION_BITS + 1,
	localparam int NW = LW + REM_W - DIV_SHIFT
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	output logic [LW-1:0] quot
);

	// Exact floor division by DIV_ODD for any num below 2**NW: multiply by the
	// rounded-up reciprocal and drop RSH bits. The rounding error stays below 16.
	localparam int RSH = NW + 4;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RSH) + DIV_ODD - 1) / DIV_ODD;
	localparam logic [NW:0] RECIP = RECIP_FULL[NW:0];

	logic [2*NW:0] q_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4 <= (2*NW+1)'(num) * (2*NW+1)'(RECIP);
		end
	end

	assign quot = q_s4[RSH +: LW];

endmodule

[sv/hsl_to_rgb_pixel.sv]
`timescale 1ns / 1ps

// Channel   | Handshake           | Payload
// ----------+---------------------+------------------------------------------
// input     | in_valid / in_ready | hue, saturation, lightness, is_null,
//           |                     | last_pixel
// output    | out_valid/out_ready | red, green, blue, null_out, end_of_row
// config    | cfg_we              | cfg_data (full-scale value)
//
// Six register stages; a pixel is offered at the output once it has passed
// through all six, and one pixel is taken per cycle while the output drains. The
// depth comes from the chroma, ramp, reciprocal-divide and full-scale multiplies.
// Reset clears the stage valid bits and sets the full-scale value to 255.
// A stage holds only while its successor is full and stalled, so the input
// keeps taking pixels until all six stages are full.

module hsl_to_rgb_pixel import hslrgb_pkg::*; #(
	parameter int LEVEL_FRACTION_BITS = DEF_LEVEL_FRACTION_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COLOR_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [HUE_W-1:0]   hue,
	input  logic [15:0]        saturation,
	input  logic [15:0]        lightness,
	input  logic               is_null,
	input  logic               last_pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COLOR_W-1:0] red,
	output logic [COLOR_W-1:0] green,
	output logic [COLOR_W-1:0] blue,
	output logic               null_out,
	output logic               end_of_row
);

	localparam int LW = LEVEL_FRACTION_BITS + 1;
	localparam int EXT_W = (LW > 16) ? LW : 16;
	localparam int PW = LW + REM_W;
	localparam int NW = PW - DIV_SHIFT;
	localparam logic [LW-1:0] ONE = {1'b1, {LEVEL_FRACTION_BITS{1'b0}}};
	localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(ONE);
	localparam logic [HUE_W-1:0] B1 = HUE_W'(SECTOR_UNITS);
	localparam logic [HUE_W-1:0] B2 = HUE_W'(2 * SECTOR_UNITS);
	localparam logic [HUE_W-1:0] B3 = HUE_W'(3 * SECTOR_UNITS);
	localparam logic [HUE_W-1:0] B4 = HUE_W'(4 * SECTOR_UNITS);
	localparam logic [HUE_W-1:0] B5 = HUE_W'(5 * SECTOR_UNITS);
	localparam logic [HUE_W-1:0] LIMIT = HUE_W'(HUE_LIMIT);
	localparam logic [REM_W-1:0] SU_REM = REM_W'(SECTOR_UNITS);

	typedef struct packed {
		logic    in_range;
		sector_t sector;
		logic    nul;
		logic    last;
	} pix_ctl_t;

	logic [COLOR_W-1:0] full_scale_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	pix_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	logic [LW-1:0]    s_s1, onemdev_s1;
	logic [LW:0]      twol_s1;
	logic [REM_W-1:0] rem_s1;

	logic [LW-1:0]    c_s2;
	logic [LW:0]      twol_s2;
	logic [REM_W-1:0] rem_eff_s2;

	logic [NW-1:0]    n_s3;
	logic [LW-1:0]    c_s3;
	logic [LW:0]      base2_s3;

	logic [LW-1:0]    c_s4;
	logic [LW:0]      base2_s4;

	logic [LW:0]      v2_s5 [3];

	logic [COLOR_W-1:0] col_s6 [3];
	logic               nul_s6, last_s6;

	// Stage enables: a stage loads when it is empty or its successor moves.
	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RESET;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (cfg_we) begin
				full_scale_q <= cfg_data;
			end
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: clamp the levels, fold the lightness, split hue into sector and ramp.
	logic [EXT_W-1:0] s_ext, l_ext;
	logic [LW-1:0]    s_cl, l_cl, dev;
	logic [LW:0]      twol;
	sector_t          sector;
	logic [HUE_W-1:0] sec_base;
	logic             in_range;
	logic [HUE_W-1:0] rem_full;

	always_comb begin
		s_ext = EXT_W'(saturation);
		l_ext = EXT_W'(lightness);
		s_cl = (s_ext > ONE_EXT) ? ONE : s_ext[LW-1:0];
		l_cl = (l_ext > ONE_EXT) ? ONE : l_ext[LW-1:0];
		twol = {l_cl, 1'b0};
		if (twol >= {1'b0, ONE}) begin
			dev = LW'(twol - {1'b0, ONE});
		end else begin
			dev = LW'({1'b0, ONE} - twol);
		end

		in_range = hue < LIMIT;
		if (hue >= B5) begin
			sector = SEC_M_R;
			sec_base = B5;
		end else if (hue >= B4) begin
			sector = SEC_B_M;
			sec_base = B4;
		end else if (hue >= B3) begin
			sector = SEC_C_B;
			sec_base = B3;
		end else if (hue >= B2) begin
			sector = SEC_G_C;
			sec_base = B2;
		end else if (hue >= B1) begin
			sector = SEC_Y_G;
			sec_base = B1;
		end else begin
			sector = SEC_R_Y;
			sec_base = '0;
		end
		// Out-of-range hue places nothing, so its ramp is forced to zero.
		rem_full = in_range ? (hue - sec_base) : '0;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			s_s1 <= s_cl;
			onemdev_s1 <= ONE - dev;
			twol_s1 <= twol;
			rem_s1 <= rem_full[REM_W-1:0];
			ctl_s1 <= '{in_range: in_range, sector: sector, nul: is_null, last: last_pixel};
		end
	end

	// Stage 2: chroma, and the ramp turned around in odd sectors.
	logic [2*LW-1:0] cprod;
	logic            odd;

	always_comb begin
		cprod = (2*LW)'(onemdev_s1) * (2*LW)'(s_s1);
		odd = ctl_s1.sector inside {SEC_Y_G, SEC_C_B, SEC_M_R};
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			c_s2 <= cprod[LEVEL_FRACTION_BITS +: LW];
			twol_s2 <= twol_s1;
			rem_eff_s2 <= odd ? (SU_REM - rem_s1) : rem_s1;
			ctl_s2 <= ctl_s1;
		end
	end

	// Stage 3: chroma times ramp; the power-of-two part of the sector width drops here.
	logic [PW-1:0] xprod;

	assign xprod = PW'(c_s2) * PW'(rem_eff_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			n_s3 <= xprod[PW-1:DIV_SHIFT];
			c_s3 <= c_s2;
			base2_s3 <= twol_s2 - {1'b0, c_s2};
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 4: the remaining divide by the odd factor of the sector width.
	logic [LW-1:0] x;

	hslrgb_ramp_div #(
		.LEVEL_FRACTION_BITS(LEVEL_FRACTION_BITS)
	) u_ramp_div (
		.clk (clk),
		.en  (en4),
		.num (n_s3),
		.quot(x)
	);

	always_ff @(posedge clk) begin
		if (en4) begin
			c_s4 <= c_s3;
			base2_s4 <= base2_s3;
			ctl_s4 <= ctl_s3;
		end
	end

	// Stage 5: place chroma and intermediate, add the doubled baseline.
	logic [LW-1:0] comp [3];

	always_comb begin
		comp[0] = '0;
		comp[1] = '0;
		comp[2] = '0;
		if (ctl_s4.in_range) begin
			case (ctl_s4.sector)
				SEC_R_Y: begin
					comp[0] = c_s4;
					comp[1] = x;
				end
				SEC_Y_G: begin
					comp[0] = x;
					comp[1] = c_s4;
				end
				SEC_G_C: begin
					comp[1] = c_s4;
					comp[2] = x;
				end
				SEC_C_B: begin
					comp[1] = x;
					comp[2] = c_s4;
				end
				SEC_B_M: begin
					comp[0] = x;
					comp[2] = c_s4;
				end
				default: begin
					comp[0] = c_s4;
					comp[2] = x;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int k = 0; k < 3; k++) begin
				v2_s5[k] <= {comp[k], 1'b0} + base2_s4;
			end
			ctl_s5 <= ctl_s4;
		end
	end

	// Stage 6: scale to full range; the extra shift bit undoes the doubling.
	logic [LW+COLOR_W:0] sprod [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sprod[k] = (LW+COLOR_W+1)'(v2_s5[k]) * (LW+COLOR_W+1)'(full_scale_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			for (int k = 0; k < 3; k++) begin
				col_s6[k] <= ctl_s5.nul ? '0 : sprod[k][LEVEL_FRACTION_BITS+1 +: COLOR_W];
			end
			nul_s6 <= ctl_s5.nul;
			last_s6 <= ctl_s5.last;
		end
	end

	assign out_valid = v_s6;
	assign red = col_s6[0];
	assign green = col_s6[1];
	assign blue = col_s6[2];
	assign null_out = nul_s6;
	assign end_of_row = last_s6;

	a_null_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && null_out |-> red == '0 && green == '0 && blue == '0)
		else $error("null pixel carries nonzero components");

	a_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> red <= full_scale_q && green <= full_scale_q && blue <= full_scale_q)
		else $error("component above full scale");

	a_ramp_le_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> x <= c_s4)
		else $error("intermediate exceeds chroma");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6)
		else $error("input stalled with an empty stage");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted pixel did not enter stage one");

endmodule

[test/tb_hsl_to_rgb_pixel.sv]
`timescale 1ns / 1ps

module tb_hsl_to_rgb_pixel;
	import hslrgb_pkg::*;

	localparam int FRAC = DEF_LEVEL_FRACTION_BITS;
	localparam int LEVEL_ONE = 1 << FRAC;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               null_px;
		logic               row_end;
	} rgb_pixel_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [COLOR_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [HUE_W-1:0]   hue = '0;
	logic [15:0]        saturation = '0;
	logic [15:0]        lightness = '0;
	logic               is_null = 1'b0;
	logic               last_pixel = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               null_out;
	logic               end_of_row;

	rgb_pixel_t         expected_pixels[$];
	logic [COLOR_W-1:0] full_scale = FULL_SCALE_RESET;
	int                 idle_pct = 0;
	int                 mismatches = 0;

	hsl_to_rgb_pixel #(
		.LEVEL_FRACTION_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.hue(hue),
		.saturation(saturation),
		.lightness(lightness),
		.is_null(is_null),
		.last_pixel(last_pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.null_out(null_out),
		.end_of_row(end_of_row)
	);

	always #1 clk = ~clk;

	// Bit-exact conversion of one pixel at the given full-scale value.
	function automatic rgb_pixel_t predict_rgb(logic [15:0] h, logic [15:0] s_in,
			logic [15:0] l_in, logic nul, logic row_end, logic [COLOR_W-1:0] scale);
		logic [63:0] one, s, l, hv, twol, dev, chroma, base2, rem, ramp, v2, scaled;
		logic [63:0] comp [3];
		logic [2:0]  sidx;
		sector_t     sec;
		rgb_pixel_t  px;
		one = 64'd1 << FRAC;
		s = (64'(s_in) > one) ? one : 64'(s_in);
		l = (64'(l_in) > one) ? one : 64'(l_in);
		hv = 64'(h);
		px = '0;
		px.null_px = nul;
		px.row_end = row_end;
		if (nul)
			return px;
		twol = 2 * l;
		dev = (twol >= one) ? twol - one : one - twol;
		chroma = ((one - dev) * s) >> FRAC;
		base2 = twol - chroma;
		comp[0] = 0;
		comp[1] = 0;
		comp[2] = 0;
		if (hv < HUE_LIMIT) begin
			sidx = 3'(hv / SECTOR_UNITS);
			sec = sector_t'(sidx);
			rem = hv % SECTOR_UNITS;
			// Odd sectors ramp down, even sectors ramp up.
			if (sidx[0])
				ramp = (chroma * (SECTOR_UNITS - rem)) / SECTOR_UNITS;
			else
				ramp = (chroma * rem) / SECTOR_UNITS;
			case (sec)
				SEC_R_Y: begin comp[0] = chroma; comp[1] = ramp; end
				SEC_Y_G: begin comp[0] = ramp; comp[1] = chroma; end
				SEC_G_C: begin comp[1] = chroma; comp[2] = ramp; end
				SEC_C_B: begin comp[1] = ramp; comp[2] = chroma; end
				SEC_B_M: begin comp[0] = ramp; comp[2] = chroma; end
				default: begin comp[0] = chroma; comp[2] = ramp; end
			endcase
		end
		for (int k = 0; k < 3; k++) begin
			v2 = 2 * comp[k] + base2;
			scaled = (v2 * 64'(scale)) >> (FRAC + 1);
			comp[k] = scaled & 64'hFFFF;
		end
		px.red = comp[0][15:0];
		px.green = comp[1][15:0];
		px.blue = comp[2][15:0];
		return px;
	endfunction

	function automatic logic [15:0] rand_level();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'(LEVEL_ONE);
			2: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, LEVEL_ONE));
		endcase
	endfunction

	function automatic logic [15:0] rand_hue();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(HUE_LIMIT, 65535));
			1: return 16'($urandom_range(1, 6) * SECTOR_UNITS - $urandom_range(0, 1));
			default: return 16'($urandom_range(0, HUE_LIMIT - 1));
		endcase
	endfunction

	task automatic send_pixel(input logic [15:0] h, input logic [15:0] s,
			input logic [15:0] l, input logic nul, input logic row_end);
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		hue <= h;
		saturation <= s;
		lightness <= l;
		is_null <= nul;
		last_pixel <= row_end;
		do
			@(posedge clk);
		while (!in_ready);
		expected_pixels.push_back(predict_rgb(h, s, l, nul, row_end, full_scale));
	endtask

	task automatic send_random_pixel();
		send_pixel(rand_hue(), rand_level(), rand_level(),
			$urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The register is only written once every pixel in flight has come out.
	task automatic set_full_scale(input logic [COLOR_W-1:0] value);
		drain_pipeline();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		full_scale = value;
	endtask

	task automatic test_directed_pixels();
		logic [15:0] mid;
		mid = 16'(LEVEL_ONE / 2);
		idle_pct = 20;
		set_full_scale(16'd255);
		send_pixel(16'd0, 16'(LEVEL_ONE), mid, 1'b0, 1'b0);
		for (int k = 0; k < 6; k++)
			send_pixel(16'(k * SECTOR_UNITS + 1234), 16'(LEVEL_ONE), mid, 1'b0, 1'b0);
		send_pixel(16'(SECTOR_UNITS - 1), 16'(LEVEL_ONE), mid, 1'b0, 1'b0);
		send_pixel(16'(SECTOR_UNITS), 16'(LEVEL_ONE), mid, 1'b0, 1'b1);
		send_pixel(16'(HUE_LIMIT - 1), 16'(LEVEL_ONE), mid, 1'b0, 1'b0);
		// Hue out of range leaves only the baseline on every component.
		send_pixel(16'(HUE_LIMIT), 16'(LEVEL_ONE), 16'd20000, 1'b0, 1'b0);
		send_pixel(16'hFFFF, 16'd12345, 16'd9000, 1'b0, 1'b0);
		send_pixel(16'd3000, 16'd0, 16'd11111, 1'b0, 1'b0);
		send_pixel(16'd3000, 16'(LEVEL_ONE), 16'd0, 1'b0, 1'b0);
		send_pixel(16'd3000, 16'(LEVEL_ONE), 16'(LEVEL_ONE), 1'b0, 1'b0);
		// Levels above one saturate to one.
		send_pixel(16'd20000, 16'hFFFF, 16'd16000, 1'b0, 1'b0);
		send_pixel(16'd20000, 16'd30000, 16'hFFFF, 1'b0, 1'b0);
		send_pixel(16'd40000, 16'(LEVEL_ONE + 1), 16'(LEVEL_ONE + 1), 1'b0, 1'b1);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		send_pixel(16'd12000, 16'd20000, 16'd15000, 1'b1, 1'b1);
		send_pixel(16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
	endtask

	task automatic test_scale_extremes();
		idle_pct = 25;
		set_full_scale(16'd1);
		repeat (60) send_random_pixel();
		set_full_scale(16'hFFFF);
		repeat (100) send_random_pixel();
	endtask

	task automatic test_random_mix();
		logic [COLOR_W-1:0] scale;
		for (int b = 0; b < 5; b++) begin
			case ($urandom_range(0, 4))
				0: scale = 16'd1;
				1: scale = 16'hFFFF;
				2: scale = 16'd1023;
				default: scale = 16'($urandom_range(1, 65535));
			endcase
			set_full_scale(scale);
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 40;
			endcase
			repeat (130) send_random_pixel();
		end
	endtask

	task automatic test_steady_stream();
		set_full_scale(16'($urandom_range(1, 65535)));
		idle_pct = 0;
		repeat (120) send_random_pixel();
	endtask

	// Output stalls: random bursts with ready low while idle_pct is nonzero.
	initial begin
		forever begin
			@(negedge clk);
			if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 16)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rgb_pixel_t got;
		rgb_pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{red, green, blue, null_out, end_of_row};
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected pixel: r=%0d g=%0d b=%0d null=%0b eor=%0b",
						red, green, blue, null_out, end_of_row);
			end else begin
				want = expected_pixels.pop_front();
				if (got.red !== want.red || got.green !== want.green ||
						got.blue !== want.blue || got.null_px !== want.null_px ||
						got.row_end !== want.row_end) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Pixel mismatch: expected r=%0d g=%0d b=%0d null=%0b eor=%0b,",
							want.red, want.green, want.blue, want.null_px, want.row_end);
						$display("  got r=%0d g=%0d b=%0d null=%0b eor=%0b",
							got.red, got.green, got.blue, got.null_px, got.row_end);
					end
				end
			end
		end
	end

	// Ends the run if no transfer happens on either channel for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_pixels();
		test_scale_extremes();
		test_random_mix();
		test_steady_stream();
		drain_pipeline();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
